// ----- design/kncs_pkg.sv -----
// Package for the k-nearest candidate selector.
// Request and register codes, cell operations and the cell control struct.
// No dependencies.
`default_nettype none

package kncs_pkg;

  // Default sizes handed to the top level
  localparam int MAX_K_DEF     = 64;
  localparam int DIST_BITS_DEF = 32;
  localparam int ID_BITS_DEF   = 32;

  // Fixed widths of the item fields and registers
  localparam int REQ_W      = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int K_REG_W    = 7;
  localparam int FOUND_W    = 7;

  localparam logic [K_REG_W-1:0]    K_RESET      = 7'd50;
  localparam logic [CFG_DATA_W-1:0] RADIUS_RESET = 32'hFFFF_FFFF;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_OFFER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_K      = 1'd1;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_INS_OPEN = 2'd1,  // insert, store not full: nearer entries move up
    CELL_INS_FULL = 2'd2,  // insert, store full: farthest entry falls out
    CELL_ROTATE   = 2'd3   // whole chain moves up by one, last wraps to first
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occupied;  // cell holds a kept entry
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/kncs_cell.sv -----
// One cell of the sorted candidate chain: holds one entry, farthest at cell 0.
// Compares the broadcast candidate and moves data to and from its neighbors.
// Depends on kncs_pkg.
`default_nettype none

module kncs_cell import kncs_pkg::*; #(
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter bit IS_FIRST  = 1'b0
) (
  input  wire logic                 clk,
  input  wire cell_ctl_t            ctl,
  input  wire logic [DIST_BITS-1:0] cand_dist,
  input  wire logic [ID_BITS-1:0]   cand_id,
  input  wire logic [DIST_BITS-1:0] left_dist,
  input  wire logic [ID_BITS-1:0]   left_id,
  input  wire logic                 left_far,
  input  wire logic [DIST_BITS-1:0] right_dist,
  input  wire logic [ID_BITS-1:0]   right_id,
  input  wire logic                 right_far,
  output logic [DIST_BITS-1:0]      entry_dist,
  output logic [ID_BITS-1:0]        id,
  output logic                      far
);

  logic [DIST_BITS-1:0] dist_r, dist_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;

  // Kept entry orders after the candidate (distance, then identifier)
  assign far = ctl.occupied &&
               ((dist_r > cand_dist) || ((dist_r == cand_dist) && (id_r > cand_id)));

  always_comb begin
    dist_nxt = dist_r;
    id_nxt   = id_r;
    case (ctl.op)
      CELL_INS_OPEN: begin
        if (!far) begin
          if (left_far || IS_FIRST) begin
            dist_nxt = cand_dist;
            id_nxt   = cand_id;
          end else begin
            dist_nxt = left_dist;
            id_nxt   = left_id;
          end
        end
      end
      CELL_INS_FULL: begin
        if (right_far) begin
          dist_nxt = right_dist;
          id_nxt   = right_id;
        end else if (far || IS_FIRST) begin
          dist_nxt = cand_dist;
          id_nxt   = cand_id;
        end
      end
      CELL_ROTATE: begin
        dist_nxt = left_dist;
        id_nxt   = left_id;
      end
      default: begin
        dist_nxt = dist_r;
        id_nxt   = id_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    id_r   <= id_nxt;
  end

  assign entry_dist = dist_r;
  assign id         = id_r;

endmodule

`default_nettype wire

// ----- design/k_nearest_candidate_selector.sv -----
// Top level of the k-nearest candidate selector: request decode, search
// radius, kept count, drain sequencer, output register and the cell chain.
// Depends on kncs_pkg and kncs_cell.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-----------------------------------
//   in_      | input     | in_valid/in_ready | req_type, cand_id, cand_dist_sq
//   out_     | output    | out_valid/ready   | radius, count, taken, entry, last
//   cfg_     | input     | cfg_we            | cfg_addr, cfg_wdata
//
// Start, offer and unused codes finish when accepted: the candidate is compared in
// every cell at once and the chain shifts in the same clock.
// A drain waits on output stalls only when it emits: the chain rotates once all
// the way round, the last count steps emit from the top cell, nearest first.
// Reset is synchronous; it clears the count and loads the radius with all
// ones. Cell contents are not reset. A stalled output blocks new requests.
`default_nettype none

module k_nearest_candidate_selector import kncs_pkg::*; #(
  parameter int MAX_K     = MAX_K_DEF,
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [REQ_W-1:0]      in_req_type,
  input  wire logic [ID_BITS-1:0]    in_cand_id,
  input  wire logic [DIST_BITS-1:0]  in_cand_dist_sq,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DIST_BITS-1:0]       out_radius_sq,
  output logic [FOUND_W-1:0]         out_found_count,
  output logic                       out_taken,
  output logic                       out_entry_valid,
  output logic [ID_BITS-1:0]         out_entry_id,
  output logic [DIST_BITS-1:0]       out_entry_dist_sq,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_K + 1);
  localparam int KW = (CW > K_REG_W) ? CW : K_REG_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rot_r, rot_nxt;
  logic [DIST_BITS-1:0] radius_r, radius_nxt;
  logic [DIST_BITS-1:0] init_radius_r;
  logic [K_REG_W-1:0]   k_used_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [DIST_BITS-1:0] out_radius_r, out_radius_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;
  logic                 out_taken_r, out_taken_nxt;
  logic                 out_ev_r, out_ev_nxt;
  logic [ID_BITS-1:0]   out_id_r, out_id_nxt;
  logic [DIST_BITS-1:0] out_dist_r, out_dist_nxt;
  logic                 out_last_r, out_last_nxt;

  // Chain wiring; entry MAX_K is the empty neighbor right of the last cell
  logic [DIST_BITS-1:0] dist_w [MAX_K+1];
  logic [ID_BITS-1:0]   id_w   [MAX_K+1];
  logic                 far_w  [MAX_K+1];
  cell_ctl_t            cell_ctl [MAX_K];
  cell_op_t             cell_op;

  logic          in_fire, out_free;
  logic [KW-1:0] k_ext, k_eff, count_ext;
  logic          store_full, take, reach_k;
  logic [CW-1:0] count_after;
  logic [DIST_BITS-1:0] radius_ins;
  logic          drain_emit, drain_step, drain_end;

  assign dist_w[MAX_K] = '0;
  assign id_w[MAX_K]   = '0;
  assign far_w[MAX_K]  = 1'b0;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    localparam int LEFT = (i == 0) ? MAX_K - 1 : i - 1;

    assign cell_ctl[i].op       = cell_op;
    assign cell_ctl[i].occupied = (CW'(i) < count_r);

    kncs_cell #(
      .DIST_BITS (DIST_BITS),
      .ID_BITS   (ID_BITS),
      .IS_FIRST  (i == 0)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .cand_dist  (in_cand_dist_sq),
      .cand_id    (in_cand_id),
      .left_dist  (dist_w[LEFT]),
      .left_id    (id_w[LEFT]),
      .left_far   (far_w[LEFT]),
      .right_dist (dist_w[i+1]),
      .right_id   (id_w[i+1]),
      .right_far  (far_w[i+1]),
      .entry_dist (dist_w[i]),
      .id         (id_w[i]),
      .far        (far_w[i])
    );
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // Effective k: zero acts as one, above MAX_K acts as MAX_K
  assign k_ext     = KW'(k_used_r);
  assign k_eff     = (k_ext == '0) ? KW'(1) :
                     (k_ext > KW'(MAX_K)) ? KW'(MAX_K) : k_ext;
  assign count_ext = KW'(count_r);

  assign store_full  = (count_ext >= k_eff);
  assign take        = (in_cand_dist_sq < radius_r);
  assign count_after = store_full ? count_r : count_r + CW'(1);
  assign reach_k     = (KW'(count_after) >= k_eff);

  // New farthest entry lands in cell 0
  always_comb begin
    if (store_full) begin
      radius_ins = far_w[1] ? dist_w[1] : in_cand_dist_sq;
    end else begin
      radius_ins = far_w[0] ? dist_w[0] : in_cand_dist_sq;
    end
  end

  // Drain: rotate MAX_K times, emit the top cell on the last count steps
  assign drain_emit = (rot_r >= (CW'(MAX_K) - count_r));
  assign drain_step = (state_r == ST_DRAIN) && (!drain_emit || out_free);
  assign drain_end  = (rot_r == CW'(MAX_K - 1));

  always_comb begin
    cell_op = CELL_HOLD;
    if (in_fire && (in_req_type == REQ_OFFER) && take) begin
      cell_op = store_full ? CELL_INS_FULL : CELL_INS_OPEN;
    end else if (drain_step) begin
      cell_op = CELL_ROTATE;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rot_nxt        = rot_r;
    radius_nxt     = radius_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_radius_nxt = out_radius_r;
    out_count_nxt  = out_count_r;
    out_taken_nxt  = out_taken_r;
    out_ev_nxt     = out_ev_r;
    out_id_nxt     = out_id_r;
    out_dist_nxt   = out_dist_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_taken_nxt  = 1'b0;
          out_ev_nxt     = 1'b0;
          out_id_nxt     = '0;
          out_dist_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_radius_nxt = radius_r;
          out_count_nxt  = count_r;
          case (in_req_type)
            REQ_START: begin
              count_nxt      = '0;
              radius_nxt     = init_radius_r;
              out_radius_nxt = init_radius_r;
              out_count_nxt  = '0;
            end
            REQ_OFFER: begin
              if (take) begin
                count_nxt     = count_after;
                out_count_nxt = count_after;
                out_taken_nxt = 1'b1;
                if (reach_k) begin
                  radius_nxt     = radius_ins;
                  out_radius_nxt = radius_ins;
                end
              end
            end
            REQ_DRAIN: begin
              // Empty store answers with one blank item
              if (count_r != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = ST_DRAIN;
                rot_nxt       = '0;
              end
            end
            default: begin
              out_taken_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (drain_step) begin
          rot_nxt = rot_r + CW'(1);
          if (drain_emit) begin
            out_valid_nxt  = 1'b1;
            out_radius_nxt = radius_r;
            out_count_nxt  = count_r;
            out_taken_nxt  = 1'b0;
            out_ev_nxt     = 1'b1;
            out_id_nxt     = id_w[MAX_K-1];
            out_dist_nxt   = dist_w[MAX_K-1];
            out_last_nxt   = drain_end;
          end
          if (drain_end) begin
            state_nxt = ST_IDLE;
            rot_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      rot_r         <= '0;
      radius_r      <= '1;
      out_valid_r   <= 1'b0;
      init_radius_r <= DIST_BITS'(RADIUS_RESET);
      k_used_r      <= K_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rot_r       <= rot_nxt;
      radius_r    <= radius_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_IDX_RADIUS: init_radius_r <= DIST_BITS'(cfg_wdata);
          CFG_IDX_K:      k_used_r      <= cfg_wdata[K_REG_W-1:0];
          default:        k_used_r      <= k_used_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_radius_r <= out_radius_nxt;
    out_count_r  <= out_count_nxt;
    out_taken_r  <= out_taken_nxt;
    out_ev_r     <= out_ev_nxt;
    out_id_r     <= out_id_nxt;
    out_dist_r   <= out_dist_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_radius_sq     = out_radius_r;
  assign out_found_count   = FOUND_W'(out_count_r);
  assign out_taken         = out_taken_r;
  assign out_entry_valid   = out_ev_r;
  assign out_entry_id      = out_id_r;
  assign out_entry_dist_sq = out_dist_r;
  assign out_last          = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_K))
    else $error("kept count above MAX_K");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> !in_ready)
    else $error("input accepted during drain");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req_type == REQ_START)) |=> (count_r == '0))
    else $error("start did not clear the store");

  a_taken_not_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_taken_r) |-> !out_ev_r)
    else $error("taken item carries an entry");

  a_idle_rot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (rot_r == '0))
    else $error("rotation count left over after drain");

endmodule

`default_nettype wire

// ----- tb/tb_k_nearest_candidate_selector.sv -----
// Testbench for k_nearest_candidate_selector: directed table, then random
// search phases, results checked against a built-in predictor or table values.
// Depends on kncs_pkg and the selector RTL.
`timescale 1ns / 1ps

module tb_k_nearest_candidate_selector import kncs_pkg::*;;

  localparam int MK = MAX_K_DEF;
  localparam int DW = DIST_BITS_DEF;
  localparam int IW = ID_BITS_DEF;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int DRAIN_SLACK  = MK + 16;  // a drain rotates the whole chain
  localparam int HOLD_CYCLES  = 400;
  localparam int END_LIMIT    = 20000;
  localparam int ITEM_TARGET  = 330;

  typedef struct packed {
    logic [DW-1:0]      radius;
    logic [FOUND_W-1:0] count;
    logic               taken;
    logic               entry_valid;
    logic [IW-1:0]      entry_id;
    logic [DW-1:0]      entry_dist;
    logic               last;
  } pick_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // For register rows arg_a is the register index and arg_b the value
  typedef struct packed {
    row_kind_t        kind;
    logic [REQ_W-1:0] req;
    logic [31:0]      arg_a;
    logic [31:0]      arg_b;
    logic             typed;
    pick_t            want;
  } row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [REQ_W-1:0]      in_req_type = REQ_START;
  logic [IW-1:0]         in_cand_id = '0;
  logic [DW-1:0]         in_cand_dist_sq = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DW-1:0]         out_radius_sq;
  logic [FOUND_W-1:0]    out_found_count;
  logic                  out_taken;
  logic                  out_entry_valid;
  logic [IW-1:0]         out_entry_id;
  logic [DW-1:0]         out_entry_dist_sq;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = CFG_IDX_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  k_nearest_candidate_selector DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_cand_id       (in_cand_id),
    .in_cand_dist_sq  (in_cand_dist_sq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_radius_sq    (out_radius_sq),
    .out_found_count  (out_found_count),
    .out_taken        (out_taken),
    .out_entry_valid  (out_entry_valid),
    .out_entry_id     (out_entry_id),
    .out_entry_dist_sq(out_entry_dist_sq),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  // Predictor state: kept list sorted nearest first
  logic [DW-1:0]      nn_dist [MK];
  logic [IW-1:0]      nn_id   [MK];
  int                 nn_count = 0;
  logic [DW-1:0]      nn_radius = '1;
  logic [DW-1:0]      reg_radius = RADIUS_RESET;
  logic [K_REG_W-1:0] reg_k = K_RESET;

  pick_t picks_due [$];
  row_t  script [$];

  bit calm = 1'b0;
  bit hold_request = 1'b0;

  int items_sent = 0;
  int drains_sent = 0;
  int offers_taken = 0;
  int results_checked = 0;
  int error_count = 0;
  int phase_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_k_nearest_candidate_selector: done, errors");
    $finish;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Append one expected result to the queue
  task automatic expect_pick(pick_t p);
    picks_due = {picks_due, p};
  endtask

  function automatic int k_effective();
    if (reg_k < 1) return 1;
    if (reg_k > MK) return MK;
    return int'(reg_k);
  endfunction

  // True if (da, ia) sorts after (db, ib): distance first, then identifier
  function automatic bit orders_after(logic [DW-1:0] da, logic [IW-1:0] ia,
                                      logic [DW-1:0] db, logic [IW-1:0] ib);
    if (da != db) return da > db;
    return ia > ib;
  endfunction

  task automatic nearest_step(logic [REQ_W-1:0] req, logic [IW-1:0] id,
                              logic [DW-1:0] cdist, logic typed, pick_t typed_pick);
    int    n;
    int    k;
    int    pos;
    int    i;
    logic  hit;
    pick_t p;
    hit = 1'b0;
    p = '0;
    case (req)
      REQ_START: begin
        nn_count = 0;
        nn_radius = reg_radius;
      end
      REQ_OFFER: begin
        if (cdist < nn_radius) begin
          k = k_effective();
          n = nn_count;
          if (n >= k) n--;  // drop the farthest
          pos = 0;
          while (pos < n && !orders_after(nn_dist[pos], nn_id[pos], cdist, id)) pos++;
          for (i = n; i > pos; i--) begin
            nn_dist[i] = nn_dist[i-1];
            nn_id[i] = nn_id[i-1];
          end
          nn_dist[pos] = cdist;
          nn_id[pos] = id;
          n++;
          nn_count = n;
          if (n >= k) nn_radius = nn_dist[n-1];
          hit = 1'b1;
          offers_taken++;
        end
      end
      REQ_DRAIN: begin
        drains_sent++;
        for (i = 0; i < nn_count; i++) begin
          p.radius = nn_radius;
          p.count = FOUND_W'(nn_count);
          p.taken = 1'b0;
          p.entry_valid = 1'b1;
          p.entry_id = nn_id[i];
          p.entry_dist = nn_dist[i];
          p.last = (i == nn_count - 1);
          expect_pick(p);
        end
      end
      default: ;
    endcase
    if (req != REQ_DRAIN || nn_count == 0) begin
      p = '0;
      p.radius = nn_radius;
      p.count = FOUND_W'(nn_count);
      p.taken = hit;
      p.last = 1'b1;
      expect_pick(typed ? typed_pick : p);
    end
  endtask

  task automatic send_item(logic [REQ_W-1:0] req, logic [IW-1:0] id,
                           logic [DW-1:0] cdist, logic typed, pick_t typed_pick);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_cand_id <= id;
    in_cand_dist_sq <= cdist;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    nearest_step(req, id, cdist, typed, typed_pick);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_RADIUS) reg_radius = value;
    else reg_k = value[K_REG_W-1:0];
  endtask

  // Hold off new items until every pending result is out and the chain is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic add_row(row_kind_t kind, logic [REQ_W-1:0] req, logic [31:0] a,
                         logic [31:0] b, logic typed, logic [DW-1:0] rad,
                         logic [FOUND_W-1:0] cnt, logic tk);
    row_t r;
    r = '0;
    r.kind = kind;
    r.req = req;
    r.arg_a = a;
    r.arg_b = b;
    r.typed = typed;
    r.want.radius = rad;
    r.want.count = cnt;
    r.want.taken = tk;
    r.want.last = 1'b1;
    script = {script, r};
  endtask

  function automatic logic [DW-1:0] pick_dist();
    case ($urandom_range(0, 4))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 15);  // dense ties
      3:       return nn_radius - $urandom_range(0, 1);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [IW-1:0] pick_id();
    if ($urandom_range(0, 1)) return $urandom;
    return $urandom_range(0, 7);
  endfunction

  // Output side: random stalls, one long hold-off on request
  initial begin : sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    pick_t want;
    if (rst_n && out_valid && out_ready) begin
      if (picks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %h dist %h",
                                  out_entry_id, out_entry_dist_sq));
      end else begin
        want = picks_due.pop_front();
        check_field("radius_sq", out_radius_sq, want.radius);
        check_field("found_count", out_found_count, want.count);
        check_field("taken", out_taken, want.taken);
        check_field("entry_valid", out_entry_valid, want.entry_valid);
        check_field("entry_id", out_entry_id, want.entry_id);
        check_field("entry_dist_sq", out_entry_dist_sq, want.entry_dist);
        check_field("last", out_last, want.last);
        results_checked++;
      end
    end
  end

  initial begin : stimulus
    bit   prev_cfg;
    int   k_eff;
    int   n_offers;
    int   half;
    int   waited;
    bit   lower_k;
    logic [CFG_DATA_W-1:0] val;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed expectations only where obvious
    add_row(ROW_ITEM, REQ_OFFER, 32'd5, 32'h100, 1, '1, 1, 1);  // offer before any start
    add_row(ROW_ITEM, REQ_DRAIN, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, REQ_START, 0, 0, 1, '1, 0, 0);
    add_row(ROW_ITEM, REQ_DRAIN, 0, 0, 1, '1, 0, 0);             // empty store
    add_row(ROW_ITEM, REQ_OFFER, 0, '1, 1, '1, 0, 0);            // equal to radius
    add_row(ROW_ITEM, REQ_OFFER, '1, 32'hFFFF_FFFE, 1, '1, 1, 1);
    add_row(ROW_ITEM, REQ_OFFER, '1, 0, 1, '1, 2, 1);
    add_row(ROW_ITEM, REQ_OFFER, 0, 0, 1, '1, 3, 1);              // tie, smaller id
    add_row(ROW_ITEM, REQ_OFFER, 32'd7, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, REQ_UNUSED, '1, 0, 1, '1, 4, 0);
    add_row(ROW_ITEM, REQ_DRAIN, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, 0, CFG_IDX_RADIUS, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, REQ_START, 0, 0, 1, 0, 0, 0);
    add_row(ROW_ITEM, REQ_OFFER, 32'd1, 0, 1, 0, 0, 0);           // zero radius
    add_row(ROW_CFG, 0, CFG_IDX_RADIUS, 32'h0100_0000, 0, 0, 0, 0);
    add_row(ROW_CFG, 0, CFG_IDX_K, 0, 0, 0, 0, 0);                // acts as 1
    add_row(ROW_ITEM, REQ_START, 0, 0, 1, 32'h0100_0000, 0, 0);
    add_row(ROW_ITEM, REQ_OFFER, 32'd9, 32'h0080_0000, 1, 32'h0080_0000, 1, 1);
    add_row(ROW_ITEM, REQ_OFFER, 32'd3, 32'h0080_0000, 1, 32'h0080_0000, 1, 0);
    add_row(ROW_ITEM, REQ_OFFER, 32'd2, 32'h007F_FFFF, 1, 32'h007F_FFFF, 1, 1);
    add_row(ROW_CFG, 0, CFG_IDX_K, 32'd127, 0, 0, 0, 0);          // acts as MAX_K
    add_row(ROW_ITEM, REQ_OFFER, 32'd4, 32'h10, 1, 32'h007F_FFFF, 2, 1);
    add_row(ROW_CFG, 0, CFG_IDX_K, 32'd1, 0, 0, 0, 0);            // k below count
    add_row(ROW_ITEM, REQ_OFFER, 32'd6, 32'h8, 0, 0, 0, 0);
    add_row(ROW_ITEM, REQ_DRAIN, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, 0, CFG_IDX_RADIUS, '1, 0, 0, 0, 0);          // waits for next start
    add_row(ROW_ITEM, REQ_OFFER, 32'd1, 32'h10, 1, 32'h10, 2, 0);

    prev_cfg = 1'b0;
    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        write_reg(script[r].arg_a[CFG_IDX_W-1:0], script[r].arg_b);
        prev_cfg = 1'b1;
      end else begin
        send_item(script[r].req, script[r].arg_a, script[r].arg_b,
                  script[r].typed, script[r].want);
        prev_cfg = 1'b0;
      end
    end

    // Random search phases
    while (items_sent < ITEM_TARGET) begin
      settle();
      phase_count++;
      calm = ($urandom_range(0, 3) == 0) || (phase_count == 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: val = $urandom_range(1, 8);
        6:                val = $urandom_range(9, 63);
        7:                val = MK;
        8:                val = 0;
        default:          val = $urandom_range(MK + 1, 127);
      endcase
      write_reg(CFG_IDX_K, val);
      case ($urandom_range(0, 7))
        0, 1, 2, 3: val = $urandom;
        4, 5:       val = '1;
        6:          val = $urandom_range(0, 300);
        default:    val = 0;
      endcase
      write_reg(CFG_IDX_RADIUS, val);

      if (phase_count % 5 == 0) begin
        // noise: any request code, any content
        repeat (10) send_item(REQ_W'($urandom_range(0, 3)), pick_id(), pick_dist(), 0, '0);
      end else begin
        if (phase_count == 3) hold_request = 1'b1;  // fill the block, stall its output
        k_eff = k_effective();
        n_offers = (k_eff <= 8) ? $urandom_range(2, 24) : $urandom_range(k_eff / 2, k_eff + 8);
        half = n_offers / 2;
        lower_k = ($urandom_range(0, 2) == 0);
        send_item(REQ_START, pick_id(), pick_dist(), 0, '0);
        for (int j = 0; j < n_offers; j++) begin
          if (lower_k && j == half) begin
            settle();
            write_reg(CFG_IDX_K, $urandom_range(1, k_eff));
            if ($urandom_range(0, 1)) write_reg(CFG_IDX_RADIUS, $urandom);
          end
          case ($urandom_range(0, 19))
            0:       send_item(REQ_DRAIN, pick_id(), pick_dist(), 0, '0);
            1:       send_item(REQ_UNUSED, pick_id(), pick_dist(), 0, '0);
            2:       send_item(REQ_START, pick_id(), pick_dist(), 0, '0);
            default: send_item(REQ_OFFER, pick_id(), pick_dist(), 0, '0);
          endcase
        end
        send_item(REQ_DRAIN, pick_id(), pick_dist(), 0, '0);
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    waited = 0;
    while (picks_due.size() != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_SLACK) @(posedge clk);
    if (picks_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", picks_due.size()));

    $display("covered %0d items over %0d search phases: %0d drains, %0d candidates kept",
             items_sent, phase_count, drains_sent, offers_taken);
    $display("%0d results compared, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("tb_k_nearest_candidate_selector: done, clean");
    end else begin
      $display("tb_k_nearest_candidate_selector: done, errors");
    end
    $finish;
  end

endmodule
